// File: src/gtfr_pkg.sv
// Package for the gap-timed frame receiver.
// Holds the input mode codes, frame kinds, header constants and the shared structs.
// No dependencies.
`default_nettype none

package gtfr_pkg;

    localparam int STORE_DEPTH = 16;

    localparam logic [7:0] HDR_BYTE    = 8'h4F;
    localparam logic [7:0] WRITE_CODE  = 8'h0C;
    localparam logic [7:0] REPORT_CODE = 8'h0A;
    localparam logic [7:0] WRITE_LEN   = 8'd15;
    localparam logic [7:0] REPORT_LEN  = 8'd13;
    localparam logic [7:0] ACK_LEN     = 8'd1;
    localparam logic [7:0] COUNT_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_TX_DONE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_WRONG  = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_WRITE  = 2'd3
    } t_kind;

    // captured frame bytes that classification looks at
    typedef struct packed {
        logic [7:0] length;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b8;
        logic [7:0] b9;
        logic [7:0] b10;
        logic [7:0] b11;
        logic [7:0] b12;
        logic [7:0] b13;
    } t_frame;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [31:0] value;
        logic [7:0]  length;
    } t_result;

endpackage

`default_nettype wire

// File: src/gap_timed_frame_receiver_unit.sv
// Gap-timed frame receiver, top level: input word register, control, classifier, result register.
// Depends on gtfr_pkg, gtfr_ctrl and gtfr_classify.
//
// Takes one input word per cycle (byte, timer tick or transmit-done) and gives one result word
// when a tick runs the gap timer out. A word is held in the input register, where the
// control state updates and the classifier decodes the captured bytes; a result lands in the
// output register on the same edge and waits there until it is taken. The input side keeps
// taking words while a result waits, stalling only when a frame-ending tick meets a full,
// stalled result register. The gap length register may be written at any time the block is
// idle.
`default_nettype none

module gap_timed_frame_receiver_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_mode,
    input  wire  [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_frame_kind,
    output logic [15:0] o_reg_address,
    output logic [31:0] o_reg_value,
    output logic [7:0]  o_frame_length,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_gap_ticks
);
    import gtfr_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_mode;
    logic [7:0]  r_data;
    logic [15:0] r_gap_ticks;
    logic        r_out_valid;
    t_result     r_result;

    logic        frame_end, out_free, step;
    t_frame      frame;
    t_result     result;

    assign out_free    = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && (!frame_end || out_free);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_gap_ticks <= 16'd2;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (i_cfg_valid) begin
                r_gap_ticks <= i_gap_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode <= i_mode;
            r_data <= i_data_byte;
        end
    end

    gtfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_mode      (r_mode),
        .i_data_byte (r_data),
        .i_gap_ticks (r_gap_ticks),
        .o_frame_end (frame_end),
        .o_frame     (frame)
    );

    gtfr_classify u_classify (
        .i_frame  (frame),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && frame_end) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_kind   = r_result.kind;
    assign o_reg_address  = r_result.address;
    assign o_reg_value    = r_result.value;
    assign o_frame_length = r_result.length;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && frame_end && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_write_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.kind == KIND_WRITE) |-> (r_result.length == WRITE_LEN))
        else $error("register write frame with wrong length");

    a_ack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.kind == KIND_ACK)
            |-> (r_result.address == 16'd0 && r_result.value == 32'd0
                 && r_result.length == ACK_LEN))
        else $error("acknowledge carries payload");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step && frame_end && r_mode == MODE_TICK))
        else $error("result without a frame-ending tick");

endmodule

`default_nettype wire

// File: src/gtfr_ctrl.sv
// Receive control: armed flag, byte count, gap timer and header/payload byte capture.
// Depends on gtfr_pkg.
`default_nettype none

module gtfr_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire [1:0]            i_mode,
    input  wire [7:0]            i_data_byte,
    input  wire [15:0]           i_gap_ticks,
    output logic                 o_frame_end,
    output gtfr_pkg::t_frame     o_frame
);
    import gtfr_pkg::*;

    logic        r_receiving, n_receiving;
    logic        r_timer_on,  n_timer_on;
    logic [7:0]  r_count,     n_count;
    logic [15:0] r_gap,       n_gap;
    logic [7:0]  r_b0, r_b1, r_b8, r_b9, r_b10, r_b11, r_b12, r_b13;
    logic        byte_wr;

    assign o_frame_end = (i_mode == MODE_TICK) && r_timer_on && (r_gap <= 16'd1);
    assign byte_wr     = i_step && (i_mode == MODE_BYTE) && r_receiving
                         && (int'(r_count) < STORE_DEPTH);

    always_comb begin
        n_receiving = r_receiving;
        n_timer_on  = r_timer_on;
        n_count     = r_count;
        n_gap       = r_gap;
        if (i_step) begin
            unique case (i_mode)
                MODE_BYTE: begin
                    if (r_receiving) begin
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 8'd1;
                        end
                        n_gap      = (i_gap_ticks != 16'd0) ? i_gap_ticks : 16'd1;
                        n_timer_on = 1'b1;
                    end
                end
                MODE_TICK: begin
                    if (r_timer_on) begin
                        if (r_gap > 16'd1) begin
                            n_gap = r_gap - 16'd1;
                        end else begin
                            n_gap       = 16'd0;
                            n_timer_on  = 1'b0;
                            n_count     = 8'd0;
                            n_receiving = 1'b0;
                        end
                    end
                end
                MODE_TX_DONE: begin
                    n_receiving = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_timer_on  <= 1'b0;
            r_count     <= 8'd0;
            r_gap       <= 16'd0;
        end else begin
            r_receiving <= n_receiving;
            r_timer_on  <= n_timer_on;
            r_count     <= n_count;
            r_gap       <= n_gap;
        end
    end

    // only positions used by classification are kept
    always_ff @(posedge i_clk) begin
        if (byte_wr) begin
            case (r_count)
                8'd0:    r_b0  <= i_data_byte;
                8'd1:    r_b1  <= i_data_byte;
                8'd8:    r_b8  <= i_data_byte;
                8'd9:    r_b9  <= i_data_byte;
                8'd10:   r_b10 <= i_data_byte;
                8'd11:   r_b11 <= i_data_byte;
                8'd12:   r_b12 <= i_data_byte;
                8'd13:   r_b13 <= i_data_byte;
                default: begin
                end
            endcase
        end
    end

    assign o_frame = '{length: r_count, b0: r_b0, b1: r_b1, b8: r_b8, b9: r_b9,
                       b10: r_b10, b11: r_b11, b12: r_b12, b13: r_b13};

endmodule

`default_nettype wire

// File: src/gtfr_classify.sv
// Frame classifier: decodes length and header into kind, address and value.
// Depends on gtfr_pkg.
`default_nettype none

module gtfr_classify (
    input  gtfr_pkg::t_frame  i_frame,
    output gtfr_pkg::t_result o_result
);
    import gtfr_pkg::*;

    logic is_write, is_report, is_ack;

    assign is_write  = (i_frame.length == WRITE_LEN) && (i_frame.b0 == HDR_BYTE)
                       && (i_frame.b1 == WRITE_CODE);
    assign is_ack    = (i_frame.length == ACK_LEN) && (i_frame.b0 == HDR_BYTE);
    assign is_report = (i_frame.length == REPORT_LEN) && (i_frame.b0 == HDR_BYTE)
                       && (i_frame.b1 == REPORT_CODE);

    always_comb begin
        o_result.kind    = KIND_WRONG;
        o_result.address = 16'd0;
        o_result.value   = 32'd0;
        o_result.length  = i_frame.length;
        if (is_write) begin
            o_result.kind    = KIND_WRITE;
            o_result.address = {i_frame.b8, i_frame.b9};
            o_result.value   = {i_frame.b12, i_frame.b13, i_frame.b10, i_frame.b11};
        end else if (is_ack) begin
            o_result.kind = KIND_ACK;
        end else if (is_report) begin
            o_result.kind    = KIND_REPORT;
            o_result.address = {i_frame.b8, i_frame.b9};
            o_result.value   = {16'd0, i_frame.b10, i_frame.b11};
        end
    end

endmodule

`default_nettype wire
